FILE: rtl/mcpg_pkg.sv
// mcpg_pkg: shared constants and helpers for the circle point generator
// no dependencies; imported by the interfaces and every rtl module

package mcpg_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int QUEUE_LOG_DEF  = 1;

  // word opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // decision update constants
  localparam int DEC_INIT  = 3;
  localparam int STEP_DIAG = 10;
  localparam int STEP_AXIS = 6;

  localparam int GROUP_POINTS = 8;
  localparam int IDX_BITS     = $clog2(GROUP_POINTS);

  // packed width of one queued group: centre, x, y and finish flag
  function automatic int group_bits(input int coord_bits);
    return 4 * coord_bits + 4;
  endfunction

endpackage

FILE: rtl/mcpg_in_if.sv
// mcpg_in_if: input channel, valid/ready with start/step command word
// depends on mcpg_pkg

interface mcpg_in_if
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-1:0] radius;

  modport source (output valid, op, center_x, center_y, radius, input ready);
  modport sink   (input valid, op, center_x, center_y, radius, output ready);
endinterface

FILE: rtl/mcpg_out_if.sv
// mcpg_out_if: output channel, valid/ready with one circle point per word
// depends on mcpg_pkg

interface mcpg_out_if
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [COORD_BITS+1:0]   point_x;
  logic signed [COORD_BITS+1:0]   point_y;
  logic                           last;
  logic                           done_res;

  modport source (output valid, point_x, point_y, last, done_res, input ready);
  modport sink   (input valid, point_x, point_y, last, done_res, output ready);
endinterface

FILE: rtl/mcpg_queue.sv
// mcpg_queue: small fifo of point groups between front and back ends
// depends on mcpg_pkg

module mcpg_queue
  import mcpg_pkg::*;
#(
  parameter int DATA_BITS = group_bits(COORD_BITS_DEF),
  parameter int DEPTH_LOG = QUEUE_LOG_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output logic [DATA_BITS-1:0] head
);
  localparam int DEPTH = 1 << DEPTH_LOG;

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DEPTH_LOG-1:0] wr_ptr;
  logic [DEPTH_LOG-1:0] rd_ptr;
  logic [DEPTH_LOG:0]   count;

  assign full      = (count == (DEPTH_LOG+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

FILE: rtl/mcpg_front.sv
// mcpg_front: takes start/step words, runs the decision update, queues groups
// depends on mcpg_pkg and mcpg_in_if

module mcpg_front
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  mcpg_in_if.sink                               in_ch,
  input  logic                                  full,
  output logic                                  push,
  output logic [group_bits(COORD_BITS)-1:0]     push_data
);
  localparam int PX = COORD_BITS + 1;
  localparam int PY = COORD_BITS + 2;
  localparam int DB = COORD_BITS + 6;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [PX-1:0]         x;
    logic [PY-1:0]         y;
    logic                  fin;
  } group_t;

  logic [PX-1:0]         pos_x,      pos_x_next;
  logic [PY-1:0]         pos_y,      pos_y_next;
  logic [DB-1:0]         decision,   decision_next;
  logic [COORD_BITS-1:0] center_col, center_col_next;
  logic [COORD_BITS-1:0] center_row, center_row_next;
  logic                  active,     active_next;

  logic          take;
  logic          is_start;
  logic [PX-1:0] x_inc;
  logic [PY-1:0] y_dec;
  logic [DB-1:0] x_ext;
  logic [DB-1:0] y_ext;
  logic [DB-1:0] r_ext;
  logic          d_pos;
  logic          fin;
  group_t        grp;

  assign in_ch.ready = !full;
  assign take        = in_ch.valid && in_ch.ready;
  assign is_start    = (in_ch.op == OP_START);

  assign x_inc = pos_x + 1'b1;
  assign y_dec = pos_y - 1'b1;
  assign x_ext = {{(DB-PX){1'b0}}, x_inc};
  assign y_ext = {{(DB-PY){y_dec[PY-1]}}, y_dec};
  assign r_ext = {{(DB-COORD_BITS){1'b0}}, in_ch.radius};
  assign d_pos = !decision[DB-1] && (decision != '0);

  always_comb begin
    pos_x_next      = pos_x;
    pos_y_next      = pos_y;
    decision_next   = decision;
    center_col_next = center_col;
    center_row_next = center_row;
    if (is_start) begin
      pos_x_next      = '0;
      pos_y_next      = {2'b00, in_ch.radius};
      decision_next   = DB'(DEC_INIT) - (r_ext << 1);
      center_col_next = in_ch.center_x;
      center_row_next = in_ch.center_y;
    end else begin
      pos_x_next = x_inc;
      if (d_pos) begin
        pos_y_next    = y_dec;
        decision_next = decision + ((x_ext - y_ext) << 2) + DB'(STEP_DIAG);
      end else begin
        decision_next = decision + (x_ext << 2) + DB'(STEP_AXIS);
      end
    end
  end

  // finished once y drops below x
  assign fin = $signed({pos_y_next[PY-1], pos_y_next}) < $signed({2'b00, pos_x_next});

  assign push        = take && (is_start || active);
  assign active_next = !fin;

  assign grp.cx  = center_col_next;
  assign grp.cy  = center_row_next;
  assign grp.x   = pos_x_next;
  assign grp.y   = pos_y_next;
  assign grp.fin = fin;
  assign push_data = grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      pos_y      <= '0;
      decision   <= '0;
      center_col <= '0;
      center_row <= '0;
      active     <= 1'b0;
    end else if (push) begin
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      decision   <= decision_next;
      center_col <= center_col_next;
      center_row <= center_row_next;
      active     <= active_next;
    end
  end
endmodule

FILE: rtl/mcpg_back.sv
// mcpg_back: expands each queued group into eight symmetric points
// depends on mcpg_pkg and mcpg_out_if

module mcpg_back
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  logic [group_bits(COORD_BITS)-1:0] head,
  output logic                              pop,
  mcpg_out_if.source                        out_ch
);
  localparam int PX = COORD_BITS + 1;
  localparam int PY = COORD_BITS + 2;
  localparam int PT = COORD_BITS + 2;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [PX-1:0]         x;
    logic [PY-1:0]         y;
    logic                  fin;
  } group_t;

  group_t        grp;
  logic [IDX_BITS-1:0] idx;
  logic          load;
  logic          last_pt;
  logic [PT-1:0] cx_e;
  logic [PT-1:0] cy_e;
  logic [PT-1:0] x_e;
  logic [PT-1:0] a_off;
  logic [PT-1:0] b_off;
  logic [PT-1:0] px;
  logic [PT-1:0] py;

  assign grp  = head;
  assign load = head_valid && (!out_ch.valid || out_ch.ready);

  assign cx_e  = {2'b00, grp.cx};
  assign cy_e  = {2'b00, grp.cy};
  assign x_e   = {1'b0, grp.x};
  // upper half swaps axes, bit 0 mirrors column, bit 1 mirrors row
  assign a_off = idx[2] ? grp.y : x_e;
  assign b_off = idx[2] ? x_e : grp.y;
  assign px    = idx[0] ? (cx_e - a_off) : (cx_e + a_off);
  assign py    = idx[1] ? (cy_e - b_off) : (cy_e + b_off);

  assign last_pt = (idx == IDX_BITS'(GROUP_POINTS - 1));
  assign pop     = load && last_pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
      idx          <= idx + 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.point_x  <= px;
      out_ch.point_y  <= py;
      out_ch.last     <= last_pt;
      out_ch.done_res <= grp.fin;
    end
  end
endmodule

FILE: rtl/midpoint_circle_point_generator.sv
// midpoint_circle_point_generator: top level of the circle point generator
// depends on mcpg_pkg, mcpg_in_if, mcpg_out_if, mcpg_front, mcpg_queue, mcpg_back
//
// in_ch takes one command word per handshake: op start loads centre and
// radius, op step advances the circle by one column. out_ch gives one
// point word per handshake, eight per start or live step, last set on
// the eighth and done_res set on all eight once y has dropped below x.
// a step with no circle in progress is taken and gives nothing.
// the front end runs the decision update in the accepting cycle and queues
// the point group; the back end turns a group into points, one per cycle
// while out_ch is ready. each group passes through the group queue and
// then the output register; the two-entry group queue lets the front end
// take words back to back until it fills.
// when out_ch stalls the output register holds its word, the queue fills
// and then in_ch.ready drops; nothing is lost or repeated.
// reset (rst, synchronous) empties the queue and output register and
// leaves no circle in progress.

module midpoint_circle_point_generator
  import mcpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int QUEUE_LOG  = QUEUE_LOG_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mcpg_in_if.sink     in_ch,
  mcpg_out_if.source  out_ch
);
  localparam int GB = group_bits(COORD_BITS);

  logic          push;
  logic [GB-1:0] push_data;
  logic          full;
  logic          pop;
  logic          not_empty;
  logic [GB-1:0] head;

  mcpg_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  mcpg_queue #(
    .DATA_BITS (GB),
    .DEPTH_LOG (QUEUE_LOG)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  mcpg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );
endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for midpoint_circle_point_generator
// depends on mcpg_pkg, mcpg_in_if, mcpg_out_if and the rtl of the generator
// a scoreboard class predicts the eight points of each start or live step

module testbench;
  import mcpg_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int PT = CB + 2;

  typedef struct {
    logic signed [PT-1:0] px;
    logic signed [PT-1:0] py;
    logic                 last;
    logic                 done;
  } circle_point_t;

  class circle_scoreboard;
    logic        [CB:0]   pos_x;
    logic signed [CB+1:0] pos_y;
    logic signed [CB+5:0] decision;
    logic        [CB-1:0] center_col;
    logic        [CB-1:0] center_row;
    bit                   active;
    circle_point_t        expected_points[$];
    int                   mismatches;
    int                   groups_made;

    function new();
      pos_x       = '0;
      pos_y       = '0;
      decision    = '0;
      center_col  = '0;
      center_row  = '0;
      active      = 1'b0;
      mismatches  = 0;
      groups_made = 0;
    endfunction

    function void add_point(int px, int py, bit lst, bit fin);
      circle_point_t p;
      p.px   = PT'(px);
      p.py   = PT'(py);
      p.last = lst;
      p.done = fin;
      expected_points.push_back(p);
    endfunction

    function void push_group();
      int x, y, cx, cy;
      bit fin;
      x   = pos_x;
      y   = pos_y;
      cx  = center_col;
      cy  = center_row;
      fin = (y < x);
      add_point(cx + x, cy + y, 1'b0, fin);
      add_point(cx - x, cy + y, 1'b0, fin);
      add_point(cx + x, cy - y, 1'b0, fin);
      add_point(cx - x, cy - y, 1'b0, fin);
      add_point(cx + y, cy + x, 1'b0, fin);
      add_point(cx - y, cy + x, 1'b0, fin);
      add_point(cx + y, cy - x, 1'b0, fin);
      add_point(cx - y, cy - x, 1'b1, fin);
      active = !fin;
      groups_made++;
    endfunction

    function void note_command(logic op, logic [CB-1:0] cx, logic [CB-1:0] cy,
                               logic [CB-1:0] r);
      int x, y, d, rad;
      logic [CB:0] nx;
      if (op == OP_START) begin
        rad        = r;
        center_col = cx;
        center_row = cy;
        pos_x      = '0;
        pos_y      = (CB+2)'(rad);
        decision   = (CB+6)'(DEC_INIT - 2 * rad);
        push_group();
      end else if (active) begin
        nx = pos_x + 1'b1;
        x  = nx;
        y  = pos_y;
        d  = decision;
        if (d > 0) begin
          pos_y = (CB+2)'(y - 1);
          y     = pos_y;
          d     = d + 4 * (x - y) + STEP_DIAG;
        end else begin
          d = d + 4 * x + STEP_AXIS;
        end
        pos_x    = nx;
        decision = (CB+6)'(d);
        push_group();
      end
    endfunction

    function void check_point(logic signed [PT-1:0] px, logic signed [PT-1:0] py,
                              logic lst, logic fin);
      circle_point_t e;
      if (expected_points.size() == 0) begin
        $error("point word (%0d,%0d) with nothing expected", px, py);
        mismatches++;
        return;
      end
      e = expected_points.pop_front();
      if (px !== e.px) begin
        $error("point_x expected %0d got %0d", e.px, px);
        mismatches++;
      end
      if (py !== e.py) begin
        $error("point_y expected %0d got %0d", e.py, py);
        mismatches++;
      end
      if (lst !== e.last) begin
        $error("last expected %0b got %0b", e.last, lst);
        mismatches++;
      end
      if (fin !== e.done) begin
        $error("done_res expected %0b got %0b", e.done, fin);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mcpg_in_if  #(.COORD_BITS(CB)) in_ch ();
  mcpg_out_if #(.COORD_BITS(CB)) out_ch ();

  midpoint_circle_point_generator #(.COORD_BITS(CB)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  circle_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // output words are checked before the input word of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_point(out_ch.point_x, out_ch.point_y, out_ch.last, out_ch.done_res);
      if (in_ch.valid && in_ch.ready)
        sb.note_command(in_ch.op, in_ch.center_x, in_ch.center_y, in_ch.radius);
    end
  end

  initial begin
    int left;
    left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        left         = hold_request;
        hold_request = 0;
      end
      if (left > 0) begin
        out_ch.ready <= 1'b0;
        left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(input logic op, input logic [CB-1:0] cx,
                           input logic [CB-1:0] cy, input logic [CB-1:0] r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.center_x <= cx;
    in_ch.center_y <= cy;
    in_ch.radius   <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_all_delivered();
    in_ch.valid <= 1'b0;
    // let the monitor note the last accepted word first
    @(negedge clk);
    while (sb.expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic draw_random_circles(input int groups_wanted);
    int goal, r, n, pick;
    goal = sb.groups_made + groups_wanted;
    while (sb.groups_made < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_word(1'($urandom_range(1)), CB'($urandom), CB'($urandom), CB'($urandom));
        continue;
      end
      r = (pick < 23) ? $urandom_range(1023) : $urandom_range(24);
      send_word(OP_START, CB'($urandom), CB'($urandom), CB'(r));
      n = $urandom_range(r * 3 / 4 + 4);
      if (n > 40)
        n = 40;
      repeat (n) send_word(OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom));
    end
  endtask

  initial begin
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_START;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.radius   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle step, zero radius, extremes, restart, junk fields
    send_word(OP_STEP, 10'd77, 10'd12, 10'd900);
    send_word(OP_START, '0, '0, '0);
    send_word(OP_STEP, '0, '0, '0);
    send_word(OP_STEP, '1, '1, '1);
    send_word(OP_START, '1, '1, '1);
    send_word(OP_STEP, '0, '0, '0);
    send_word(OP_STEP, '0, '0, '0);
    send_word(OP_START, '0, '0, '1);
    send_word(OP_STEP, '1, '1, '1);
    send_word(OP_STEP, '1, '1, '0);
    send_word(OP_START, 10'd512, 10'd341, 10'd1);
    send_word(OP_STEP, '0, '0, '0);
    send_word(OP_STEP, '0, '0, '0);
    send_word(OP_START, 10'd5, 10'd1000, 10'd2);
    repeat (4) send_word(OP_STEP, '0, '1, '0);
    send_word(OP_START, 10'd300, 10'd3, 10'd7);
    repeat (6) send_word(OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom));
    wait_all_delivered();

    draw_random_circles(70);

    send_idle_pct  = 88;
    recv_stall_pct = 0;
    draw_random_circles(70);

    send_idle_pct  = 0;
    recv_stall_pct = 88;
    draw_random_circles(70);

    send_idle_pct  = 7;
    recv_stall_pct = 7;
    draw_random_circles(70);

    // long receiver hold-off while words keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_all_delivered();
    @(negedge clk);
    hold_request = 300;
    @(posedge clk);
    send_word(OP_START, 10'd500, 10'd500, 10'd60);
    repeat (30) send_word(OP_STEP, CB'($urandom), CB'($urandom), CB'($urandom));
    wait_all_delivered();

    draw_random_circles(70);
    wait_all_delivered();
    repeat (20) @(posedge clk);

    if (sb.expected_points.size() != 0) begin
      $error("%0d point words never arrived", sb.expected_points.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mcpg_pkg.sv
rtl/mcpg_in_if.sv
rtl/mcpg_out_if.sv
rtl/mcpg_queue.sv
rtl/mcpg_front.sv
rtl/mcpg_back.sv
rtl/midpoint_circle_point_generator.sv
dv/testbench.sv
